>>> rtl/htw_pkg.sv
package htw_pkg;

	// Field and register widths.
	localparam int unsigned COORD_W = 12;
	localparam int unsigned CUT_W   = 24;
	localparam int unsigned GAIN_W  = 17;
	localparam int unsigned RATE_W  = 31;
	localparam int unsigned CFG_W   = 31;

	// Coordinates at or beyond this bound lie outside the frequency plane.
	localparam logic [COORD_W:0] MAX_DIM = 13'd4096;

	// Integer parts of the exponent at or above this limit give exp(-x) = 0.
	localparam int unsigned   EXP_INT_LIMIT = 17;
	localparam logic [4:0]    EXP_INT_TOP   = 5'd17;

	// Q1.30 constants.
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF = 31'h2000_0000;

	localparam logic [GAIN_W-1:0] WEIGHT_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		REG_CENTER_ROW = 3'd0,
		REG_CENTER_COL = 3'd1,
		REG_CUTOFF_SQ  = 3'd2,
		REG_GAMMA_SPAN = 3'd3,
		REG_GAMMA_LOW  = 3'd4,
		REG_ATTEN_RATE = 3'd5
	} htw_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} htw_in_t;

	typedef struct packed {
		logic [GAIN_W-1:0] weight;
		logic              in_band;
	} htw_out_t;

endpackage

>>> rtl/homomorphic_transfer_weight_top.sv
// Homomorphic filter transfer weight. Each input beat carries one frequency-plane
// coordinate (row, col); each output beat carries the Q1.16 weight for it and an
// in_band flag. The squared distance d from the configured center is compared with
// cutoff_sq; inside the band the weight is gamma_span * (1 - exp(-atten_rate * d))
// + gamma_low, saturated to 17 bits, outside it (or beyond the plane) it is zero.
// exp(-x) splits x into an integer part, looked up in a 17-entry table of exp(-n),
// and a fraction, looked up in an EXP_TABLE_DEPTH+1 entry table with linear
// interpolation; integer parts of 17 or more give exactly zero. Both tables are
// constants computed at elaboration. The datapath is a 12-stage pipeline with at
// most one multiplication in the path of any stage, so a beat is accepted every
// clock while in_stall is low; its result is driven on the output port from the
// stage 12 register. Each stage holds its beat only while the stage after it is
// full and stalled, so bubbles are squeezed out and in_stall rises only when all
// twelve stages hold data and out_stall is high. Configuration registers are
// written through cfg_wr/cfg_addr/cfg_data and must only change while the
// pipeline is empty; unknown register indexes are ignored.
module homomorphic_transfer_weight_top #(
	parameter int unsigned EXP_TABLE_DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  htw_pkg::htw_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output htw_pkg::htw_out_t        out_data,
	input  logic                     cfg_wr,
	input  logic [2:0]               cfg_addr,
	input  logic [htw_pkg::CFG_W-1:0] cfg_data
);
	import htw_pkg::*;

	localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int unsigned P_W   = 40 + IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EXP_TABLE_DEPTH - 1);

	// Unsigned quotient by restoring shift and subtract.
	function automatic longint unsigned long_quot(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-num/EXP_TABLE_DEPTH) in Q1.30 by a truncated alternating series.
	function automatic logic [30:0] frac_entry(input int unsigned num);
		longint unsigned sum;
		longint unsigned term;
		sum  = 64'(Q30_ONE);
		term = 64'(Q30_ONE);
		for (int k = 1; k <= 20; k++) begin
			term = long_quot(term * 64'(num), 64'(EXP_TABLE_DEPTH) * 64'(k));
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum[30:0];
	endfunction

	// exp(-n) in Q1.30, built by repeated rounded multiplication by exp(-1).
	function automatic logic [30:0] int_entry(input int unsigned n);
		longint unsigned v;
		longint unsigned e1;
		v  = 64'(Q30_ONE);
		e1 = 64'(frac_entry(EXP_TABLE_DEPTH));
		for (int k = 1; k < EXP_INT_LIMIT; k++) begin
			if (k <= n) begin
				v = (v * e1 + 64'(Q30_HALF)) >> 30;
			end
		end
		return v[30:0];
	endfunction

	logic [30:0] frac_rom [0:EXP_TABLE_DEPTH];
	logic [30:0] int_rom  [0:EXP_INT_LIMIT-1];

	for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_frac
		localparam logic [30:0] FRAC_VAL = frac_entry(g);
		assign frac_rom[g] = FRAC_VAL;
	end

	for (genvar g = 0; g < EXP_INT_LIMIT; g++) begin : g_int
		localparam logic [30:0] INT_VAL = int_entry(g);
		assign int_rom[g] = INT_VAL;
	end

	// Configuration registers.
	logic [COORD_W-1:0] center_row_q;
	logic [COORD_W-1:0] center_col_q;
	logic [CUT_W-1:0]   cutoff_sq_q;
	logic [GAIN_W-1:0]  gamma_span_q;
	logic [GAIN_W-1:0]  gamma_low_q;
	logic [RATE_W-1:0]  atten_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_row_q <= '0;
			center_col_q <= '0;
			cutoff_sq_q  <= '0;
			gamma_span_q <= 17'h10000;
			gamma_low_q  <= '0;
			atten_rate_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_CENTER_ROW: center_row_q <= cfg_data[COORD_W-1:0];
				REG_CENTER_COL: center_col_q <= cfg_data[COORD_W-1:0];
				REG_CUTOFF_SQ:  cutoff_sq_q  <= cfg_data[CUT_W-1:0];
				REG_GAMMA_SPAN: gamma_span_q <= cfg_data[GAIN_W-1:0];
				REG_GAMMA_LOW:  gamma_low_q  <= cfg_data[GAIN_W-1:0];
				REG_ATTEN_RATE: atten_rate_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and load enables. A stage loads when it is empty or
	// when the stage after it moves on.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11, en12;

	always_comb begin
		en12 = !vld_s12 || !out_stall;
		en11 = !vld_s11 || en12;
		en10 = !vld_s10 || en11;
		en9  = !vld_s9  || en10;
		en8  = !vld_s8  || en9;
		en7  = !vld_s7  || en8;
		en6  = !vld_s6  || en7;
		en5  = !vld_s5  || en6;
		en4  = !vld_s4  || en5;
		en3  = !vld_s3  || en4;
		en2  = !vld_s2  || en3;
		en1  = !vld_s1  || en2;
	end

	assign in_stall  = !en1;
	assign out_valid = vld_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (en1)  vld_s1  <= in_valid;
			if (en2)  vld_s2  <= vld_s1;
			if (en3)  vld_s3  <= vld_s2;
			if (en4)  vld_s4  <= vld_s3;
			if (en5)  vld_s5  <= vld_s4;
			if (en6)  vld_s6  <= vld_s5;
			if (en7)  vld_s7  <= vld_s6;
			if (en8)  vld_s8  <= vld_s7;
			if (en9)  vld_s9  <= vld_s8;
			if (en10) vld_s10 <= vld_s9;
			if (en11) vld_s11 <= vld_s10;
			if (en12) vld_s12 <= vld_s11;
		end
	end

	// Stage 1: distances from the center and the plane bound.
	logic [COORD_W-1:0] dr_s1, dc_s1;
	logic               inpl_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			dr_s1   <= (in_data.row > center_row_q) ? in_data.row - center_row_q
				: center_row_q - in_data.row;
			dc_s1   <= (in_data.col > center_col_q) ? in_data.col - center_col_q
				: center_col_q - in_data.col;
			inpl_s1 <= ({1'b0, in_data.row} < MAX_DIM) && ({1'b0, in_data.col} < MAX_DIM);
		end
	end

	// Stage 2: squares.
	logic [2*COORD_W-1:0] sqr_s2, sqc_s2;
	logic                 inpl_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			sqr_s2  <= dr_s1 * dr_s1;
			sqc_s2  <= dc_s1 * dc_s1;
			inpl_s2 <= inpl_s1;
		end
	end

	// Stage 3: squared distance and band test.
	logic [2*COORD_W:0] d_s3;
	logic               band_s3;
	logic [2*COORD_W:0] d_sum;

	assign d_sum = {1'b0, sqr_s2} + {1'b0, sqc_s2};

	always_ff @(posedge clk) begin
		if (en3) begin
			d_s3    <= d_sum;
			band_s3 <= inpl_s2 && (d_sum <= {1'b0, cutoff_sq_q});
		end
	end

	// Stage 4: exponent x = atten_rate * d in Q.40.
	logic [RATE_W+2*COORD_W:0] x_s4;
	logic                      band_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			x_s4    <= atten_rate_q * d_s3;
			band_s4 <= band_s3;
		end
	end

	// Stage 5: split into integer part and table position.
	logic [P_W-1:0]   pos;
	logic [IDX_W-1:0] pos_idx;
	logic             big;
	logic [IDX_W-1:0] idx_s5;
	logic [15:0]      w_s5;
	logic [4:0]       n_s5;
	logic             zero_s5, band_s5;

	assign pos     = x_s4[39:0] * P_W'(EXP_TABLE_DEPTH);
	assign pos_idx = pos[P_W-1:40];
	assign big     = (x_s4[RATE_W+2*COORD_W:45] != '0) || (x_s4[44:40] >= EXP_INT_TOP);

	always_ff @(posedge clk) begin
		if (en5) begin
			idx_s5  <= (pos_idx > IDX_LAST) ? IDX_LAST : pos_idx;
			w_s5    <= pos[39:24];
			n_s5    <= x_s4[44:40];
			zero_s5 <= big;
			band_s5 <= band_s4;
		end
	end

	// Stage 6: table reads.
	logic [30:0] a_s6, b_s6, ie_s6;
	logic [15:0] w_s6;
	logic        zero_s6, band_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			a_s6    <= frac_rom[idx_s5];
			b_s6    <= frac_rom[idx_s5 + IDX_W'(1)];
			ie_s6   <= zero_s5 ? '0 : int_rom[n_s5];
			w_s6    <= w_s5;
			zero_s6 <= zero_s5;
			band_s6 <= band_s5;
		end
	end

	// Stage 7: interpolation product.
	logic [46:0] dw_s7;
	logic [30:0] a_s7, ie_s7;
	logic        zero_s7, band_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			dw_s7   <= (a_s6 - b_s6) * w_s6;
			a_s7    <= a_s6;
			ie_s7   <= ie_s6;
			zero_s7 <= zero_s6;
			band_s7 <= band_s6;
		end
	end

	// Stage 8: interpolated fraction.
	logic [30:0] fr_s8, ie_s8;
	logic        zero_s8, band_s8;

	always_ff @(posedge clk) begin
		if (en8) begin
			fr_s8   <= a_s7 - dw_s7[46:16];
			ie_s8   <= ie_s7;
			zero_s8 <= zero_s7;
			band_s8 <= band_s7;
		end
	end

	// Stage 9: exp(-n) * exp(-fraction).
	logic [61:0] pe_s9;
	logic        zero_s9, band_s9;

	always_ff @(posedge clk) begin
		if (en9) begin
			pe_s9   <= ie_s8 * fr_s8;
			zero_s9 <= zero_s8;
			band_s9 <= band_s8;
		end
	end

	// Stage 10: round to Q1.30, clamp to one, form 1 - e.
	logic [62:0] pe_rnd;
	logic [32:0] e_full;
	logic [30:0] e_cl;
	logic [30:0] om_s10;
	logic        band_s10;

	assign pe_rnd = {1'b0, pe_s9} + 63'(Q30_HALF);
	assign e_full = pe_rnd[62:30];

	always_comb begin
		if (zero_s9) begin
			e_cl = '0;
		end else if (e_full > 33'(Q30_ONE)) begin
			e_cl = Q30_ONE;
		end else begin
			e_cl = e_full[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en10) begin
			om_s10   <= Q30_ONE - e_cl;
			band_s10 <= band_s9;
		end
	end

	// Stage 11: scale by the gain span.
	logic [47:0] ps_s11;
	logic        band_s11;

	always_ff @(posedge clk) begin
		if (en11) begin
			ps_s11   <= gamma_span_q * om_s10;
			band_s11 <= band_s10;
		end
	end

	// Stage 12: round, add the low gain, saturate.
	logic [48:0] ps_rnd;
	logic [18:0] w_sum;
	htw_out_t    res_s12;

	assign ps_rnd = {1'b0, ps_s11} + 49'(Q30_HALF);
	assign w_sum  = ps_rnd[48:30] + 19'(gamma_low_q);

	always_ff @(posedge clk) begin
		if (en12) begin
			res_s12.in_band <= band_s11;
			if (!band_s11) begin
				res_s12.weight <= '0;
			end else if (w_sum > 19'(WEIGHT_MAX)) begin
				res_s12.weight <= WEIGHT_MAX;
			end else begin
				res_s12.weight <= w_sum[GAIN_W-1:0];
			end
		end
	end

	assign out_data = res_s12;

`ifndef NO_ASSERTIONS
	// The input side stalls only when the output is held and stages 1, 6, 11 and 12 are full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s6 && vld_s11 && vld_s12 && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	// The fraction table must be non-increasing between neighboring entries.
	a_tab_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (a_s6 >= b_s6))
		else $error("exp fraction table not monotonic");

	// The interpolated fraction never exceeds one.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (fr_s8 <= Q30_ONE))
		else $error("interpolated fraction above one");

	// Out-of-band results carry zero weight.
	a_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.in_band) |-> (out_data.weight == '0))
		else $error("out-of-band beat with nonzero weight");
`endif

endmodule
